### src/wffa_pkg.sv
package wffa_pkg;

	localparam int MAX_BLOCKS_DEF = 16;
	localparam int ADDR_BITS_DEF  = 16;

	localparam int FIELD_ADDR_W = 16;
	localparam int SIZE_W       = 16;
	localparam int HELD_W       = 5;

	typedef enum logic [0:0] {
		REQ_ADD   = 1'b0,
		REQ_ALLOC = 1'b1
	} req_type_t;

	typedef enum logic [1:0] {
		ST_ALLOC = 2'd0,
		ST_NOFIT = 2'd1,
		ST_ADDED = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef struct packed {
		req_type_t               req_type;
		logic [FIELD_ADDR_W-1:0] block_start;
		logic [SIZE_W-1:0]       amount;
	} req_t;

	typedef struct packed {
		status_t                 status;
		logic [FIELD_ADDR_W-1:0] alloc_addr;
		logic [HELD_W-1:0]       blocks_held;
	} rsp_t;

	// search token handed from cell to cell
	typedef struct packed {
		logic              valid;
		logic              found;
		logic [SIZE_W-1:0] left;
	} tok_t;

	// broadcast table operation
	typedef struct packed {
		logic write;
		logic update;
		logic shift;
	} cmd_t;

endpackage

### src/wffa_cell.sv
module wffa_cell #(
	parameter int MAX_BLOCKS = wffa_pkg::MAX_BLOCKS_DEF,
	parameter int ADDR_BITS  = wffa_pkg::ADDR_BITS_DEF,
	parameter int IDX        = 0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  wffa_pkg::tok_t                    tok_in,
	input  logic [$clog2(MAX_BLOCKS)-1:0]     tok_idx_in,
	input  logic [ADDR_BITS-1:0]              tok_start_in,
	output wffa_pkg::tok_t                    tok_out,
	output logic [$clog2(MAX_BLOCKS)-1:0]     tok_idx_out,
	output logic [ADDR_BITS-1:0]              tok_start_out,
	input  logic [$clog2(MAX_BLOCKS+1)-1:0]   count,
	input  logic [wffa_pkg::SIZE_W-1:0]       amt,
	input  wffa_pkg::cmd_t                    cmd,
	input  logic [$clog2(MAX_BLOCKS)-1:0]     cmd_idx,
	input  logic [ADDR_BITS-1:0]              wr_start,
	input  logic [wffa_pkg::SIZE_W-1:0]       wr_size,
	input  logic [ADDR_BITS-1:0]              nb_start,
	input  logic [wffa_pkg::SIZE_W-1:0]       nb_size,
	output logic [ADDR_BITS-1:0]              start_out,
	output logic [wffa_pkg::SIZE_W-1:0]       size_out
);

	localparam int IDX_W = $clog2(MAX_BLOCKS);
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int SUM_W = (ADDR_BITS > wffa_pkg::SIZE_W) ? ADDR_BITS : wffa_pkg::SIZE_W;

	logic [ADDR_BITS-1:0]        start_q;
	logic [wffa_pkg::SIZE_W-1:0] size_q;
	logic                        tok_valid_q;
	logic                        tok_found_q;
	logic [wffa_pkg::SIZE_W-1:0] tok_left_q;
	logic [IDX_W-1:0]            tok_idx_q;
	logic [ADDR_BITS-1:0]        tok_start_q;

	logic                        in_range;
	logic                        fits;
	logic                        take;
	logic                        here;
	logic [wffa_pkg::SIZE_W-1:0] left;
	logic [SUM_W-1:0]            adv;

	assign in_range = CNT_W'(IDX) < count;
	assign fits     = in_range && (size_q >= amt);
	assign left     = size_q - amt;
	// strictly greater keeps the earliest entry on a tie
	assign take     = tok_in.valid && fits && (!tok_in.found || (left > tok_in.left));
	assign here     = cmd_idx == IDX_W'(IDX);
	assign adv      = SUM_W'(start_q) + SUM_W'(amt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else begin
			tok_valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			tok_found_q <= 1'b1;
			tok_left_q  <= left;
			tok_idx_q   <= IDX_W'(IDX);
			tok_start_q <= start_q;
		end else begin
			tok_found_q <= tok_in.found;
			tok_left_q  <= tok_in.left;
			tok_idx_q   <= tok_idx_in;
			tok_start_q <= tok_start_in;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write && here) begin
			start_q <= wr_start;
			size_q  <= wr_size;
		end else if (cmd.update && here) begin
			start_q <= adv[ADDR_BITS-1:0];
			size_q  <= wr_size;
		end else if (cmd.shift && (IDX_W'(IDX) >= cmd_idx)) begin
			start_q <= nb_start;
			size_q  <= nb_size;
		end
	end

	assign tok_out       = '{valid: tok_valid_q, found: tok_found_q, left: tok_left_q};
	assign tok_idx_out   = tok_idx_q;
	assign tok_start_out = tok_start_q;
	assign start_out     = start_q;
	assign size_out      = size_q;

endmodule

### src/worst_fit_free_block_allocator_core.sv
// Worst-fit free block allocator. The free table is a row of MAX_BLOCKS cells, one block
// per cell. Raise start with req while busy is low; the transfer happens at that edge.
// An add's result strobes done in the next cycle and a new request may be given at once.
// An allocate is paced by the search token that walks the cell row one cell per clock; the
// chosen block is updated, or removed with the later cells shifting down in one step, at
// the edge the token leaves the last cell. Each result is on rsp for exactly one cycle with
// done high and cannot be held off, so the receiver must take it then.
module worst_fit_free_block_allocator_core #(
	parameter int MAX_BLOCKS = wffa_pkg::MAX_BLOCKS_DEF,
	parameter int ADDR_BITS  = wffa_pkg::ADDR_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  wffa_pkg::req_t req,
	output logic           done,
	output wffa_pkg::rsp_t rsp
);

	localparam int IDX_W  = $clog2(MAX_BLOCKS);
	localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
	localparam int HWID_W = (CNT_W > wffa_pkg::HELD_W) ? CNT_W : wffa_pkg::HELD_W;
	localparam int AIN_W  = (ADDR_BITS > wffa_pkg::FIELD_ADDR_W) ? ADDR_BITS
	                                                             : wffa_pkg::FIELD_ADDR_W;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SCAN = 2'b10
	} state_t;

	state_t                      state_q;
	logic [CNT_W-1:0]            count_q;
	logic [wffa_pkg::SIZE_W-1:0] amt_q;
	logic                        inj_q;
	logic                        done_q;
	wffa_pkg::rsp_t              rsp_q;

	wffa_pkg::tok_t              tok_c   [MAX_BLOCKS+1];
	logic [IDX_W-1:0]            idx_c   [MAX_BLOCKS+1];
	logic [ADDR_BITS-1:0]        tst_c   [MAX_BLOCKS+1];
	logic [ADDR_BITS-1:0]        cstart  [MAX_BLOCKS];
	logic [wffa_pkg::SIZE_W-1:0] csize   [MAX_BLOCKS];

	wffa_pkg::cmd_t              cmd;
	logic [IDX_W-1:0]            cmd_idx;
	logic [ADDR_BITS-1:0]        wr_start;
	logic [wffa_pkg::SIZE_W-1:0] wr_size;
	logic [AIN_W-1:0]            start_wide;
	logic [AIN_W-1:0]            grant_wide;
	logic                        accept;
	logic                        is_add;
	logic                        full;
	logic                        fin;
	wffa_pkg::tok_t              last;
	logic [CNT_W-1:0]            cnt_next;
	logic [HWID_W-1:0]           held_wide;

	assign accept = start && !busy;
	assign is_add = req.req_type == wffa_pkg::REQ_ADD;
	assign full   = count_q == CNT_W'(MAX_BLOCKS);
	assign last   = tok_c[MAX_BLOCKS];
	assign fin    = last.valid;

	assign start_wide = AIN_W'(req.block_start);
	assign wr_start   = start_wide[ADDR_BITS-1:0];
	assign grant_wide = AIN_W'(tst_c[MAX_BLOCKS]);

	always_comb begin
		cmd.write  = accept && is_add && !full;
		cmd.update = fin && last.found && (last.left != '0);
		cmd.shift  = fin && last.found && (last.left == '0);
		cmd_idx    = cmd.write ? count_q[IDX_W-1:0] : idx_c[MAX_BLOCKS];
		wr_size    = cmd.write ? req.amount : last.left;
		if (cmd.write) begin
			cnt_next = count_q + CNT_W'(1);
		end else if (cmd.shift) begin
			cnt_next = count_q - CNT_W'(1);
		end else begin
			cnt_next = count_q;
		end
		held_wide = HWID_W'(cnt_next);
	end

	assign tok_c[0] = '{valid: inj_q, found: 1'b0, left: '0};
	assign idx_c[0] = '0;
	assign tst_c[0] = '0;

	for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
		localparam int NB = (i < MAX_BLOCKS - 1) ? i + 1 : i;

		wffa_cell #(
			.MAX_BLOCKS(MAX_BLOCKS),
			.ADDR_BITS (ADDR_BITS),
			.IDX       (i)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.tok_in       (tok_c[i]),
			.tok_idx_in   (idx_c[i]),
			.tok_start_in (tst_c[i]),
			.tok_out      (tok_c[i+1]),
			.tok_idx_out  (idx_c[i+1]),
			.tok_start_out(tst_c[i+1]),
			.count        (count_q),
			.amt          (amt_q),
			.cmd          (cmd),
			.cmd_idx      (cmd_idx),
			.wr_start     (wr_start),
			.wr_size      (wr_size),
			.nb_start     (cstart[NB]),
			.nb_size      (csize[NB]),
			.start_out    (cstart[i]),
			.size_out     (csize[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			inj_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			count_q <= cnt_next;
			inj_q   <= 1'b0;
			done_q  <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (is_add) begin
							done_q <= 1'b1;
						end else begin
							inj_q   <= 1'b1;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (fin) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !is_add) begin
			amt_q <= req.amount;
		end
		if (accept && is_add) begin
			rsp_q.status      <= full ? wffa_pkg::ST_FULL : wffa_pkg::ST_ADDED;
			rsp_q.alloc_addr  <= '0;
			rsp_q.blocks_held <= held_wide[wffa_pkg::HELD_W-1:0];
		end else if (fin) begin
			rsp_q.status      <= last.found ? wffa_pkg::ST_ALLOC : wffa_pkg::ST_NOFIT;
			rsp_q.alloc_addr  <= last.found ? grant_wide[wffa_pkg::FIELD_ADDR_W-1:0] : '0;
			rsp_q.blocks_held <= held_wide[wffa_pkg::HELD_W-1:0];
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;
	assign rsp  = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_BLOCKS))
		else $error("free table count beyond capacity");

	a_no_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> !done_q)
		else $error("result strobe during search");

	a_token_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		last.valid |-> (state_q == S_SCAN))
		else $error("search token left the row outside a search");

	a_alloc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !is_add) |=> busy)
		else $error("allocate transfer did not start a search");

	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (rsp_q.status != wffa_pkg::ST_ALLOC)) |-> (rsp_q.alloc_addr == '0))
		else $error("address given without an allocation");

endmodule
